// ===== hdl/ip_fragment_hole_tracker_core_macros.svh =====
// ----------------------------------------------------------------------------
// ip_fragment_hole_tracker_core_macros
// assertion macros shared by the hole tracker modules
// ----------------------------------------------------------------------------
`ifndef IP_FRAGMENT_HOLE_TRACKER_CORE_MACROS_SVH
`define IP_FRAGMENT_HOLE_TRACKER_CORE_MACROS_SVH

// same-cycle implication
`define IPFHT_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define IPFHT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/ipfht_pkg.sv =====
// ----------------------------------------------------------------------------
// ipfht_pkg
// types and constants of the ip fragment hole tracker
// ----------------------------------------------------------------------------
`default_nettype none

package ipfht_pkg;

   localparam int TIMER_W = 15;

   localparam logic [15:0] OPEN_END      = 16'hffff;
   localparam logic [15:0] LAST_BYTE_MAX = 16'hfffe;

   localparam logic [2:0] ST_PARTIAL   = 3'd0;
   localparam logic [2:0] ST_COMPLETE  = 3'd1;
   localparam logic [2:0] ST_NO_HOLE   = 3'd2;
   localparam logic [2:0] ST_NO_CTX    = 3'd3;
   localparam logic [2:0] ST_HOLE_FULL = 3'd4;
   localparam logic [2:0] ST_TICK_DONE = 3'd5;

   typedef struct packed {
      logic        func;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [7:0]  protocol;
      logic [15:0] datagram_id;
      logic [12:0] frag_offset;
      logic        more_fragments;
      logic [15:0] total_len;
      logic [3:0]  header_words;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [2:0]  slot;
      logic [15:0] datagram_len;
      logic [5:0]  first_header_len;
      logic [3:0]  expired_count;
   } rsp_type;

   typedef struct packed {
      logic        tick;
      logic        empty;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [7:0]  protocol;
      logic [15:0] datagram_id;
      logic [15:0] ffirst;
      logic [15:0] flast;
      logic        mf;
      logic [5:0]  hdr;
   } cmd_type;

   typedef struct packed {
      logic [31:0]        src_addr;
      logic [31:0]        dst_addr;
      logic [7:0]         protocol;
      logic [15:0]        datagram_id;
      logic [TIMER_W-1:0] timer;
      logic [15:0]        length;
      logic               length_known;
      logic [5:0]         header_len;
   } ctx_entry_type;

endpackage

`default_nettype wire

// ===== hdl/ipfht_front.sv =====
// ----------------------------------------------------------------------------
// ipfht_front
// takes request words, works out byte range and key, queues them for the back end
// ----------------------------------------------------------------------------
`default_nettype none
`include "ip_fragment_hole_tracker_core_macros.svh"

module ipfht_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ipfht_pkg::req_type req_data,
   output logic              cmd_valid,
   input  logic              cmd_ready,
   output ipfht_pkg::cmd_type cmd
);
   import ipfht_pkg::*;

   cmd_type     q_ff [2];
   logic [1:0]  cnt_ff;
   logic        wr_ptr_ff;
   logic        rd_ptr_ff;
   logic        push;
   logic        pop;
   cmd_type     cls;
   logic [5:0]  hdr;
   logic [15:0] ffirst;
   logic [16:0] last_sum;

   assign req_ready = (cnt_ff != 2'd2);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = q_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = cmd_valid && cmd_ready;

   always_comb begin
      hdr      = {req_data.header_words, 2'b00};
      ffirst   = {req_data.frag_offset, 3'b000};
      last_sum = 17'(ffirst) + 17'(req_data.total_len - 16'(hdr)) - 17'd1;
      cls.tick        = req_data.func;
      cls.empty       = (req_data.total_len <= 16'(hdr));
      cls.src_addr    = req_data.src_addr;
      cls.dst_addr    = req_data.dst_addr;
      cls.protocol    = req_data.protocol;
      cls.datagram_id = req_data.datagram_id;
      cls.ffirst      = ffirst;
      cls.flast       = (last_sum > 17'(LAST_BYTE_MAX)) ? LAST_BYTE_MAX : last_sum[15:0];
      cls.mf          = req_data.more_fragments;
      cls.hdr         = hdr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         if (push) begin
            q_ff[wr_ptr_ff] <= cls;
            wr_ptr_ff       <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 2'd1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 2'd1;
         end
      end
   end

   `IPFHT_ASSERT_SAME(a_cnt_bound, 1'b1, cnt_ff <= 2'd2, "queue count out of range")
   `IPFHT_ASSERT_NEXT(a_cnt_up, push && !pop, cnt_ff == $past(cnt_ff) + 2'd1, "push lost")
   `IPFHT_ASSERT_NEXT(a_cnt_down, pop && !push, cnt_ff == $past(cnt_ff) - 2'd1, "pop lost")

endmodule

`default_nettype wire

// ===== hdl/ipfht_back.sv =====
// ----------------------------------------------------------------------------
// ipfht_back
// context lookup, hole list rewrite, timer ticks and result register
// ----------------------------------------------------------------------------
`default_nettype none
`include "ip_fragment_hole_tracker_core_macros.svh"

module ipfht_back #(
   parameter int CONTEXT_SLOTS     = 8,
   parameter int HOLES_PER_CONTEXT = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             cmd_valid,
   output logic                             cmd_ready,
   input  ipfht_pkg::cmd_type               cmd,
   input  logic [ipfht_pkg::TIMER_W-1:0]    timeout,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output ipfht_pkg::rsp_type               rsp_data
);
   import ipfht_pkg::*;

   localparam int SW     = $clog2(CONTEXT_SLOTS);
   localparam int SCW    = $clog2(CONTEXT_SLOTS + 1);
   localparam int CW     = $clog2(HOLES_PER_CONTEXT + 1);
   localparam int TDEPTH = 2 * HOLES_PER_CONTEXT;
   localparam int TW     = $clog2(TDEPTH);
   localparam int TCW    = $clog2(TDEPTH + 1);
   localparam int HT     = CONTEXT_SLOTS * HOLES_PER_CONTEXT;
   localparam int HAW    = $clog2(HT);

   typedef enum logic [3:0] {
      S_IDLE, S_LK_RD, S_LK_CMP, S_H_RD, S_H_PROC, S_H_WR2, S_DECIDE,
      S_CP_RD, S_CP_WR, S_T_RD, S_T_UPD, S_OUT
   } state_type;

   state_type              state_ff;
   cmd_type                cmd_ff;
   logic [SCW-1:0]         c_ff;
   logic [SW-1:0]          slot_ff;
   logic [SW-1:0]          free_ff;
   logic                   free_found_ff;
   logic                   fresh_ff;
   logic                   ovl_ff;
   logic [CW-1:0]          k_ff;
   logic [CW-1:0]          cnt_cur_ff;
   logic [TCW-1:0]         m_ff;
   logic [31:0]            pend_ff;
   ctx_entry_type          cur_ff;
   logic [SCW-1:0]         exp_ff;
   rsp_type                res_ff;
   rsp_type                rsp_data_ff;
   logic                   rsp_valid_ff;
   logic [CONTEXT_SLOTS-1:0] ctx_valid_ff;

   ctx_entry_type          ctx_mem [CONTEXT_SLOTS];
   logic [CW-1:0]          cnt_mem [CONTEXT_SLOTS];
   logic [31:0]            hole_mem [HT];
   logic [31:0]            tbuf_mem [TDEPTH];
   ctx_entry_type          ctx_rd_ff;
   logic [CW-1:0]          cnt_rd_ff;
   logic [31:0]            hole_rd_ff;
   logic [31:0]            tbuf_rd_ff;

   logic [SW-1:0]          c_idx;
   logic [HAW-1:0]         hole_addr;
   logic [15:0]            hf;
   logic [15:0]            hl;
   logic                   hit;
   logic                   need_a;
   logic                   need_b;
   logic                   emit_vld;
   logic [15:0]            ef;
   logic [15:0]            el;
   logic                   trim;
   logic                   keep;
   logic                   tbuf_we;
   logic [31:0]            tbuf_wdata;
   logic                   key_hit;
   logic [CW-1:0]          nh;
   ctx_entry_type          new_ent;
   ctx_entry_type          tick_ent;
   logic                   ctx_we;
   logic [SW-1:0]          ctx_waddr;
   ctx_entry_type          ctx_wdata;
   logic [CW-1:0]          cnt_wdata;
   logic                   hole_we;
   logic [31:0]            slot_ext;
   logic [31:0]            exp_ext;

   assign cmd_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign c_idx     = c_ff[SW-1:0];
   assign hole_addr = HAW'(32'(slot_ff) * HOLES_PER_CONTEXT + 32'(k_ff));
   assign slot_ext  = 32'(slot_ff);
   assign exp_ext   = 32'(exp_ff);
   assign nh        = fresh_ff ? CW'(1) : cnt_cur_ff;

   assign key_hit = (ctx_rd_ff.src_addr == cmd_ff.src_addr) &&
                    (ctx_rd_ff.dst_addr == cmd_ff.dst_addr) &&
                    (ctx_rd_ff.protocol == cmd_ff.protocol) &&
                    (ctx_rd_ff.datagram_id == cmd_ff.datagram_id);

   // hole split and trim
   always_comb begin
      hf     = fresh_ff ? 16'h0000 : hole_rd_ff[31:16];
      hl     = fresh_ff ? OPEN_END : hole_rd_ff[15:0];
      hit    = !((cmd_ff.ffirst > hl) || (cmd_ff.flast < hf));
      need_a = (cmd_ff.ffirst > hf);
      need_b = (cmd_ff.flast < hl);
      emit_vld = 1'b0;
      ef       = hf;
      el       = hl;
      if (state_ff == S_H_PROC) begin
         if (!hit) begin
            emit_vld = 1'b1;
         end else if (need_a) begin
            emit_vld = 1'b1;
            el       = cmd_ff.ffirst - 16'd1;
         end else if (need_b) begin
            emit_vld = 1'b1;
            ef       = cmd_ff.flast + 16'd1;
         end
      end else if (state_ff == S_H_WR2) begin
         emit_vld = 1'b1;
         ef       = pend_ff[31:16];
         el       = pend_ff[15:0];
      end
      trim       = !cmd_ff.mf && (el == OPEN_END);
      keep       = !(trim && (ef > cmd_ff.flast));
      tbuf_we    = emit_vld && keep;
      tbuf_wdata = {ef, trim ? cmd_ff.flast : el};
   end

   // context entry updates
   always_comb begin
      new_ent = cur_ff;
      if (fresh_ff) begin
         new_ent.src_addr     = cmd_ff.src_addr;
         new_ent.dst_addr     = cmd_ff.dst_addr;
         new_ent.protocol     = cmd_ff.protocol;
         new_ent.datagram_id  = cmd_ff.datagram_id;
         new_ent.length       = 16'd0;
         new_ent.length_known = 1'b0;
         new_ent.header_len   = 6'd0;
      end
      new_ent.timer = timeout;
      if (!cmd_ff.mf) begin
         new_ent.length       = cmd_ff.flast + 16'd1;
         new_ent.length_known = 1'b1;
      end
      if (cmd_ff.ffirst == 16'd0) begin
         new_ent.header_len = cmd_ff.hdr;
      end
      tick_ent = ctx_rd_ff;
      if (ctx_rd_ff.timer != '0) begin
         tick_ent.timer = ctx_rd_ff.timer - TIMER_W'(1);
      end
   end

   always_comb begin
      ctx_we    = 1'b0;
      ctx_waddr = c_idx;
      ctx_wdata = tick_ent;
      cnt_wdata = cnt_rd_ff;
      if (state_ff == S_DECIDE) begin
         ctx_we    = ovl_ff && (m_ff <= TCW'(HOLES_PER_CONTEXT));
         ctx_waddr = slot_ff;
         ctx_wdata = new_ent;
         cnt_wdata = CW'(m_ff);
      end else if (state_ff == S_T_UPD) begin
         ctx_we = (tick_ent.timer != '0);
      end
      hole_we = (state_ff == S_CP_WR);
   end

   always_ff @(posedge clock) begin
      ctx_rd_ff  <= ctx_mem[c_idx];
      cnt_rd_ff  <= cnt_mem[c_idx];
      hole_rd_ff <= hole_mem[hole_addr];
      tbuf_rd_ff <= tbuf_mem[TW'(k_ff)];
      if (ctx_we) begin
         ctx_mem[ctx_waddr] <= ctx_wdata;
         cnt_mem[ctx_waddr] <= cnt_wdata;
      end
      if (hole_we) begin
         hole_mem[hole_addr] <= tbuf_rd_ff;
      end
      if (tbuf_we) begin
         tbuf_mem[m_ff[TW-1:0]] <= tbuf_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         ctx_valid_ff <= '0;
         m_ff         <= '0;
      end else begin
         if (rsp_valid_ff && rsp_ready && (state_ff != S_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         if (tbuf_we) begin
            m_ff <= m_ff + TCW'(1);
         end
         unique case (state_ff)
            S_IDLE: begin
               if (cmd_valid) begin
                  cmd_ff        <= cmd;
                  c_ff          <= '0;
                  exp_ff        <= '0;
                  free_found_ff <= 1'b0;
                  if (cmd.tick) begin
                     state_ff <= S_T_RD;
                  end else if (cmd.empty) begin
                     res_ff   <= '{status: ST_NO_HOLE, default: '0};
                     state_ff <= S_OUT;
                  end else begin
                     state_ff <= S_LK_RD;
                  end
               end
            end
            S_LK_RD: begin
               k_ff   <= '0;
               m_ff   <= '0;
               ovl_ff <= 1'b0;
               if (c_ff == SCW'(CONTEXT_SLOTS)) begin
                  if (free_found_ff) begin
                     slot_ff  <= free_ff;
                     fresh_ff <= 1'b1;
                     state_ff <= S_H_RD;
                  end else begin
                     res_ff   <= '{status: ST_NO_CTX, default: '0};
                     state_ff <= S_OUT;
                  end
               end else if (!ctx_valid_ff[c_idx]) begin
                  if (!free_found_ff) begin
                     free_ff       <= c_idx;
                     free_found_ff <= 1'b1;
                  end
                  c_ff <= c_ff + SCW'(1);
               end else begin
                  state_ff <= S_LK_CMP;
               end
            end
            S_LK_CMP: begin
               if (key_hit) begin
                  slot_ff    <= c_idx;
                  fresh_ff   <= 1'b0;
                  cur_ff     <= ctx_rd_ff;
                  cnt_cur_ff <= cnt_rd_ff;
                  state_ff   <= S_H_RD;
               end else begin
                  c_ff     <= c_ff + SCW'(1);
                  state_ff <= S_LK_RD;
               end
            end
            S_H_RD: begin
               if (k_ff == nh) begin
                  state_ff <= S_DECIDE;
               end else begin
                  state_ff <= S_H_PROC;
               end
            end
            S_H_PROC: begin
               if (hit) begin
                  ovl_ff <= 1'b1;
               end
               if (hit && need_a && need_b) begin
                  pend_ff  <= {cmd_ff.flast + 16'd1, hl};
                  state_ff <= S_H_WR2;
               end else begin
                  k_ff     <= k_ff + CW'(1);
                  state_ff <= S_H_RD;
               end
            end
            S_H_WR2: begin
               k_ff     <= k_ff + CW'(1);
               state_ff <= S_H_RD;
            end
            S_DECIDE: begin
               k_ff     <= '0;
               state_ff <= S_OUT;
               if (!ovl_ff) begin
                  res_ff <= '{status: ST_NO_HOLE, slot: slot_ext[2:0],
                              first_header_len: fresh_ff ? 6'd0 : cur_ff.header_len,
                              default: '0};
               end else if (m_ff > TCW'(HOLES_PER_CONTEXT)) begin
                  res_ff <= '{status: ST_HOLE_FULL, slot: slot_ext[2:0], default: '0};
               end else if (m_ff == '0) begin
                  ctx_valid_ff[slot_ff] <= 1'b0;
                  res_ff <= '{status: ST_COMPLETE, slot: slot_ext[2:0],
                              datagram_len: new_ent.length_known ? new_ent.length : 16'd0,
                              first_header_len: new_ent.header_len, default: '0};
               end else begin
                  ctx_valid_ff[slot_ff] <= 1'b1;
                  res_ff <= '{status: ST_PARTIAL, slot: slot_ext[2:0],
                              first_header_len: new_ent.header_len, default: '0};
                  state_ff <= S_CP_RD;
               end
            end
            S_CP_RD: begin
               if (TCW'(k_ff) == m_ff) begin
                  state_ff <= S_OUT;
               end else begin
                  state_ff <= S_CP_WR;
               end
            end
            S_CP_WR: begin
               k_ff     <= k_ff + CW'(1);
               state_ff <= S_CP_RD;
            end
            S_T_RD: begin
               if (c_ff == SCW'(CONTEXT_SLOTS)) begin
                  res_ff   <= '{status: ST_TICK_DONE, expired_count: exp_ext[3:0],
                                default: '0};
                  state_ff <= S_OUT;
               end else if (!ctx_valid_ff[c_idx]) begin
                  c_ff <= c_ff + SCW'(1);
               end else begin
                  state_ff <= S_T_UPD;
               end
            end
            S_T_UPD: begin
               if (tick_ent.timer == '0) begin
                  ctx_valid_ff[c_idx] <= 1'b0;
                  exp_ff              <= exp_ff + SCW'(1);
               end
               c_ff     <= c_ff + SCW'(1);
               state_ff <= S_T_RD;
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_data_ff  <= res_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   `IPFHT_ASSERT_SAME(a_tbuf_bound, 1'b1, m_ff <= TCW'(TDEPTH), "hole buffer overrun")
   `IPFHT_ASSERT_NEXT(a_out_load, state_ff == S_OUT && (!rsp_valid_ff || rsp_ready),
      rsp_valid_ff && state_ff == S_IDLE, "result not loaded")
   `IPFHT_ASSERT_SAME(a_done_freed, state_ff == S_OUT && res_ff.status == ST_COMPLETE,
      !ctx_valid_ff[slot_ff], "completed context still valid")

endmodule

`default_nettype wire

// ===== hdl/ip_fragment_hole_tracker_core.sv =====
// ----------------------------------------------------------------------------
// ip_fragment_hole_tracker_core
// ipv4 reassembly tracking by hole descriptors, one status word per request
// ----------------------------------------------------------------------------
// req_ carries fragment or tick words (valid/ready); rsp_ returns one status
// word per request (valid/ready); csr_we/csr_wdata load the context timeout.
// a fragment searches the context slots one by one, walks its holes and writes the
// new hole list back one hole at a time; the context scan and the single-port
// hole memory set its time. an empty fragment goes straight to the result with
// a no-hole status. a tick visits every slot in turn and counts the expiries.
// a two-word input queue takes new requests while the back end works and a
// result waits in the output register; if the receiver stalls, the back end
// holds its finished word and stops, and the queue fills, then req_ready drops.
// reset frees all contexts and loads a timeout of 3 ticks; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module ip_fragment_hole_tracker_core #(
   parameter int CONTEXT_SLOTS     = 8,
   parameter int HOLES_PER_CONTEXT = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  ipfht_pkg::req_type            req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output ipfht_pkg::rsp_type            rsp_data,
   input  logic                          csr_we,
   input  logic [ipfht_pkg::TIMER_W-1:0] csr_wdata
);
   import ipfht_pkg::*;

   logic [TIMER_W-1:0] timeout_ff;
   logic               cmd_valid;
   logic               cmd_ready;
   cmd_type            cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMER_W'(3);
      end else if (csr_we) begin
         timeout_ff <= csr_wdata;
      end
   end

   ipfht_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd)
   );

   ipfht_back #(
      .CONTEXT_SLOTS     (CONTEXT_SLOTS),
      .HOLES_PER_CONTEXT (HOLES_PER_CONTEXT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd),
      .timeout   (timeout_ff),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
